>>> sv/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, constants and octave arithmetic for the scale pitch quantizer.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Q8.8 pitch and Q4.8 octave-reduced widths
  localparam int PITCH_W  = 16;
  localparam int DEG_W    = 12;
  localparam int DIFF_W   = DEG_W + 1;
  localparam int CFG_IDX_W = 2;

  // One octave in Q8.8 and the "no degree yet" distance
  localparam logic [DEG_W-1:0] OCTAVE_Q8 = 12'd3072;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PITCH_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE    = 2'd1;

  // Command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_PRIME,
    ST_SCAN,
    ST_DONE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;    // latch the incoming beat
    logic load_wr;    // append the latched degree
    logic scan_init;  // start the table walk at entry 0
    logic scan_step;  // compare one entry, fetch the next
    logic finish;     // form and register the result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic count_zero;
    logic last;       // entry under compare is the last valid one
  } dp_status_t;

  // 7-bit value mod 3: sum base-4 digits, fold once more, one subtract
  function automatic logic [1:0] mod3_7b(input logic [6:0] v);
    logic [3:0] s;
    logic [2:0] t;
    s = {2'b00, v[1:0]} + {2'b00, v[3:2]} + {2'b00, v[5:4]} + {3'b000, v[6]};
    t = {1'b0, s[1:0]} + {1'b0, s[3:2]};
    if (t >= 3'd3) begin
      t = t - 3'd3;
    end
    return t[1:0];
  endfunction

  // x mod 3072 = ((x >> 10) mod 3) * 1024 + (x mod 1024)
  function automatic logic [DEG_W-1:0] mod_octave(input logic [16:0] x);
    return {mod3_7b(x[16:10]), x[9:0]};
  endfunction

endpackage
`default_nettype wire

>>> sv/scale_pitch_quantizer_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// scale_pitch_quantizer_core
// Snaps Q8.8 pitches to the nearest degree of a loaded scale table.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat: start high while busy is low. cmd selects load (append one
//   degree, optionally clearing the table first) or query (snap a pitch).
//   A load gives no result.
//   A query with N loaded degrees is walked one table entry per cycle from
//   the single read port of the degree RAM; busy stays high through the
//   prime, the walk and the finish, and result_valid is high in the cycle
//   busy drops. An empty table skips the walk.
//   The result is held in an output register, so a new beat may be accepted
//   in the same cycle the strobe is up.
//   Results are shown for exactly one cycle; the receiver cannot stall them.
//   Config: cfg_valid with cfg_ready (always high), cfg_index 0 = pitch
//   offset, 1 = tolerance; other indexes are ignored. Write only when idle.
//   Reset (rst, synchronous) empties the table and zeroes both registers.
// ----------------------------------------------------------------------------
module scale_pitch_quantizer_core #(
  parameter int MAX_DEGREES = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // command channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          cmd,
  input  wire logic                          clear_first,
  input  wire logic [spq_pkg::PITCH_W-1:0]   degree_pitch,
  input  wire logic [spq_pkg::PITCH_W-1:0]   query_pitch,
  // config channel
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [spq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [spq_pkg::DEG_W-1:0]     cfg_data,
  // result
  output logic                               result_valid,
  output logic                               matched,
  output logic [spq_pkg::PITCH_W-1:0]        snapped_pitch,
  output logic                               table_empty
);

  import spq_pkg::*;

  ctrl_cmd_t  ctl;
  dp_status_t status;

  // Sequencer
  spq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cmd    (cmd),
    .busy   (busy),
    .status (status),
    .ctl    (ctl)
  );

  // Table and search datapath
  spq_datapath #(
    .MAX_DEGREES (MAX_DEGREES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .clear_first   (clear_first),
    .degree_pitch  (degree_pitch),
    .query_pitch   (query_pitch),
    .ctl           (ctl),
    .status        (status),
    .result_valid  (result_valid),
    .matched       (matched),
    .snapped_pitch (snapped_pitch),
    .table_empty   (table_empty)
  );

endmodule
`default_nettype wire

>>> sv/spq_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> sv/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_ctrl
// Sequencer: accepts a beat, runs a load or a table walk, triggers the result.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic               cmd,
  output logic                    busy,
  input  wire spq_pkg::dp_status_t status,
  output spq_pkg::ctrl_cmd_t      ctl
);

  import spq_pkg::*;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl.capture = 1'b1;
          if (cmd == CMD_LOAD) begin
            state_next = ST_LOAD;
          end else if (status.count_zero) begin
            state_next = ST_DONE;
          end else begin
            state_next = ST_PRIME;
          end
        end
      end
      ST_LOAD: begin
        ctl.load_wr = 1'b1;
        state_next  = ST_IDLE;
      end
      ST_PRIME: begin
        ctl.scan_init = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        ctl.scan_step = 1'b1;
        if (status.last) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        ctl.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> sv/spq_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spq_datapath
// Config registers, degree table, nearest-degree search and result register.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int MAX_DEGREES = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // config channel
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [spq_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [spq_pkg::DEG_W-1:0]         cfg_data,
  // input beat fields
  input  wire logic                              clear_first,
  input  wire logic [spq_pkg::PITCH_W-1:0]       degree_pitch,
  input  wire logic [spq_pkg::PITCH_W-1:0]       query_pitch,
  // control
  input  wire spq_pkg::ctrl_cmd_t                ctl,
  output spq_pkg::dp_status_t                    status,
  // result
  output logic                                   result_valid,
  output logic                                   matched,
  output logic [spq_pkg::PITCH_W-1:0]            snapped_pitch,
  output logic                                   table_empty
);

  import spq_pkg::*;

  localparam int CNT_W = $clog2(MAX_DEGREES + 1);
  localparam int AW    = (MAX_DEGREES > 1) ? $clog2(MAX_DEGREES) : 1;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_DEGREES);

  logic [DEG_W-1:0]   pitch_offset;
  logic [DEG_W-1:0]   tolerance;
  logic [CNT_W-1:0]   degree_count;
  logic [CNT_W-1:0]   count_base;
  logic               clr;
  logic [PITCH_W-1:0] deg;
  logic [PITCH_W-1:0] qry;
  logic [DEG_W-1:0]   rem;
  logic               empty;
  logic [16:0]        deg_sum;
  logic [DEG_W-1:0]   deg_red;
  logic               wr_en;
  logic [AW-1:0]      rd_idx;
  logic [AW-1:0]      cmp_idx;
  logic [AW-1:0]      raddr;
  logic [DEG_W-1:0]   ram_q;
  logic [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]  diff_neg;
  logic [DEG_W-1:0]   absd;
  logic [DIFF_W-1:0]  best;
  logic [DEG_W-1:0]   best_abs;
  logic               hit;
  logic [17:0]        snap_sum;
  logic [PITCH_W-1:0] snap_sat;

  // Config registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pitch_offset <= '0;
      tolerance    <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PITCH_OFFSET) begin
        pitch_offset <= cfg_data;
      end else if (cfg_index == REG_TOLERANCE) begin
        tolerance <= cfg_data;
      end
    end
  end

  // Beat capture; query pitch reduced to one octave on the way in
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      clr   <= clear_first;
      deg   <= degree_pitch;
      qry   <= query_pitch;
      rem   <= mod_octave({1'b0, query_pitch});
      empty <= (degree_count == '0);
    end
  end

  // Load: offset, reduce, append unless full
  assign deg_sum    = {1'b0, deg} + {5'b0, pitch_offset};
  assign deg_red    = mod_octave(deg_sum);
  assign count_base = clr ? '0 : degree_count;
  assign wr_en      = ctl.load_wr && (count_base < MAX_CNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      degree_count <= '0;
    end else if (ctl.load_wr) begin
      degree_count <= wr_en ? count_base + CNT_W'(1) : count_base;
    end
  end

  // Degree table
  assign raddr = ctl.scan_step ? rd_idx : '0;

  spq_ram #(
    .WIDTH (DEG_W),
    .DEPTH (MAX_DEGREES),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count_base[AW-1:0]),
    .wdata (deg_red),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Walk indexes: fetch runs one entry ahead of compare
  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      rd_idx  <= AW'(1);
      cmp_idx <= '0;
    end else if (ctl.scan_step) begin
      rd_idx  <= rd_idx + AW'(1);
      cmp_idx <= cmp_idx + AW'(1);
    end
  end

  assign status.count_zero = (degree_count == '0);
  assign status.last       = (CNT_W'(cmp_idx) == degree_count - CNT_W'(1));

  // Signed distance from reduced query to the entry under compare
  assign diff     = {1'b0, ram_q} - {1'b0, rem};
  assign diff_neg = '0 - diff;
  assign absd     = diff[DIFF_W-1] ? diff_neg[DEG_W-1:0] : diff[DEG_W-1:0];

  // Running tolerance hit and nearest degree, first one wins ties
  always_ff @(posedge clk) begin
    if (ctl.scan_init) begin
      hit      <= 1'b0;
      best     <= {1'b0, OCTAVE_Q8};
      best_abs <= OCTAVE_Q8;
    end else if (ctl.scan_step) begin
      if (absd <= tolerance) begin
        hit <= 1'b1;
      end
      if (absd < best_abs) begin
        best     <= diff;
        best_abs <= absd;
      end
    end
  end

  // Snap and saturate to 0..65535
  assign snap_sum = {{5{best[DIFF_W-1]}}, best} + {2'b00, qry};

  always_comb begin
    if (snap_sum[17]) begin
      snap_sat = '0;
    end else if (snap_sum[16]) begin
      snap_sat = '1;
    end else begin
      snap_sat = snap_sum[PITCH_W-1:0];
    end
  end

  // Result register, strobed for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= ctl.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      if (empty) begin
        matched       <= 1'b0;
        snapped_pitch <= qry;
        table_empty   <= 1'b1;
      end else begin
        matched       <= hit;
        snapped_pitch <= snap_sat;
        table_empty   <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire
